FILE: hdl/qsud_pkg.sv
// ----------------------------------------------------------------------------
// qsud_pkg
// Shared types, character codes and escape lookup for the string decoder.
// ----------------------------------------------------------------------------
package qsud_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA  = 2'd0;
    localparam kind_t KIND_END   = 2'd1;
    localparam kind_t KIND_NOQ   = 2'd2;
    localparam kind_t KIND_BADHX = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Fixed 256-entry escape table; unknown escapes map to zero.
    function automatic logic [7:0] escape_lut(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h00;
        case (c)
            CH_BSL:   r = 8'h5C;
            CH_QUOTE: r = 8'h22;
            CH_ZERO:  r = 8'h00;
            CH_A:     r = 8'h07;
            CH_B:     r = 8'h08;
            CH_T:     r = 8'h09;
            CH_N:     r = 8'h0A;
            CH_V:     r = 8'h0B;
            CH_F:     r = 8'h0C;
            CH_R:     r = 8'h0D;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    // Bit 4 set means "not a hex digit".
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b0, 4'(c - 8'h37)};
        else
            r = 5'h10;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

FILE: hdl/quoted_string_unescape_decoder.sv
// ----------------------------------------------------------------------------
// quoted_string_unescape_decoder
// Decodes a double-quoted C-style string literal, one character per request.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     in_valid, in_stall, char_in      char_in: one raw character
//  output    out_valid, out_stall,            decoded byte and its kind
//            out_byte, kind
//
//  One character per cycle while no result is blocked; a result passes from
//  the input register to the result register. The phase state machine
//  updates in the same cycle a character leaves the input register.
//  Reset (rst_n low, async) empties both registers and returns to idle.
//  A stalled result holds; the input register still drains characters that
//  make no result, so in_stall rises only when a result is blocked behind it.
// ----------------------------------------------------------------------------
module quoted_string_unescape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind
);

    // Input register
    logic       in_v_reg;
    logic [7:0] char_reg;

    // Decoder state
    qsud_pkg::phase_t phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;

    // Result register
    logic            out_v_reg;
    logic [7:0]      byte_reg;
    qsud_pkg::kind_t kind_reg;

    // Combinational decode of the held character
    logic            res_v;
    logic [7:0]      res_byte;
    qsud_pkg::kind_t res_kind;
    logic [4:0]      hexv;

    logic advance;
    logic out_free;

    assign hexv     = qsud_pkg::hex_value(char_reg);
    assign out_free = !out_v_reg || !out_stall;
    // The held character moves on if it makes no result or the result slot frees.
    assign advance  = in_v_reg && (!res_v || out_free);
    assign in_stall = in_v_reg && !advance;

    // Next-state logic
    always_comb
    begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        case (phase_reg)
            qsud_pkg::PH_BODY:
            begin
                if (char_reg == qsud_pkg::CH_QUOTE)
                    phase_next = qsud_pkg::PH_IDLE;
                else if (char_reg == qsud_pkg::CH_BSL)
                    phase_next = qsud_pkg::PH_ESC;
            end
            qsud_pkg::PH_ESC:
            begin
                if (char_reg == qsud_pkg::CH_X)
                    phase_next = qsud_pkg::PH_HEX1;
                else
                    phase_next = qsud_pkg::PH_BODY;
            end
            qsud_pkg::PH_HEX1:
            begin
                if (hexv[4])
                    phase_next = qsud_pkg::PH_BODY;
                else
                begin
                    phase_next = qsud_pkg::PH_HEX2;
                    nib_next   = hexv[3:0];
                end
            end
            qsud_pkg::PH_HEX2:
            begin
                phase_next = qsud_pkg::PH_BODY;
            end
            default:
            begin
                // Idle, and any unused code behaves as idle.
                if (char_reg == qsud_pkg::CH_QUOTE)
                    phase_next = qsud_pkg::PH_BODY;
                else
                    phase_next = qsud_pkg::PH_IDLE;
            end
        endcase
    end

    // Output logic
    always_comb
    begin
        res_v    = 1'b0;
        res_byte = 8'h00;
        res_kind = qsud_pkg::KIND_DATA;
        case (phase_reg)
            qsud_pkg::PH_BODY:
            begin
                if (char_reg == qsud_pkg::CH_QUOTE)
                begin
                    res_v    = 1'b1;
                    res_kind = qsud_pkg::KIND_END;
                end
                else if (char_reg != qsud_pkg::CH_BSL)
                begin
                    res_v    = 1'b1;
                    res_byte = char_reg;
                end
            end
            qsud_pkg::PH_ESC:
            begin
                if (char_reg != qsud_pkg::CH_X)
                begin
                    res_v    = 1'b1;
                    res_byte = qsud_pkg::escape_lut(char_reg);
                end
            end
            qsud_pkg::PH_HEX1:
            begin
                if (hexv[4])
                begin
                    res_v    = 1'b1;
                    res_kind = qsud_pkg::KIND_BADHX;
                end
            end
            qsud_pkg::PH_HEX2:
            begin
                res_v = 1'b1;
                if (hexv[4])
                    res_kind = qsud_pkg::KIND_BADHX;
                else
                    res_byte = {nib_reg, hexv[3:0]};
            end
            default:
            begin
                if (!qsud_pkg::is_space(char_reg) && char_reg != qsud_pkg::CH_QUOTE)
                begin
                    res_v    = 1'b1;
                    res_kind = qsud_pkg::KIND_NOQ;
                end
            end
        endcase
    end

    // Input register: reload whenever empty or its character moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (!in_v_reg || advance)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            char_reg <= char_in;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qsud_pkg::PH_IDLE;
            nib_reg   <= 4'h0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_free)
            out_v_reg <= advance && res_v;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_v)
        begin
            byte_reg <= res_byte;
            kind_reg <= res_kind;
        end
    end

    assign out_valid = out_v_reg;
    assign out_byte  = byte_reg;
    assign kind      = kind_reg;

endmodule

FILE: bench/quoted_string_unescape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_decoder_tb
// Feeds raw characters into the string decoder and checks every decoded byte
// and marker. A short table of hand-picked characters comes first, then
// random literals with escapes, hex forms and junk. The bench keeps its own
// decoder state and predicts each result. Both handshakes idle and stall at
// random, with one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module quoted_string_unescape_decoder_tb;

    // Characters the bench needs beyond those in the package; CH_LOWER_F has the value of CH_F.
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_G = 8'h67;
    localparam logic [7:0] CH_UPPER_G = 8'h47;
    localparam logic [7:0] CH_LOWER_Q = 8'h71;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam int ITEM_COUNT  = 1650;
    localparam int HOLD_CYCLES = 80;
    localparam int REPORT_MAX  = 10;

    // One decoded result: the byte and what it means.
    typedef struct packed {
        logic [7:0]      val;
        qsud_pkg::kind_t kind;
    } decoded_t;

    // One row of the hand-written table. When pinned, the expected result is
    // the one typed into the row; otherwise the bench's decoder supplies it.
    typedef struct packed {
        logic [7:0]      ch;
        logic            pinned;
        logic            gives;
        logic [7:0]      val;
        qsud_pkg::kind_t kind;
    } vector_t;

    localparam vector_t DIRECTED [25] = '{
        '{CH_UPPER_Z, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_NOQ},      // junk before quote
        '{8'hFF, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_NOQ},           // top byte, still idle
        '{qsud_pkg::CH_SPACE, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA}, // blank skipped
        '{qsud_pkg::CH_QUOTE, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA}, // opens literal
        '{8'h00, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_DATA},          // lowest plain byte
        '{8'hFF, 1'b1, 1'b1, 8'hFF, qsud_pkg::KIND_DATA},          // highest plain byte
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{qsud_pkg::CH_N, 1'b1, 1'b1, 8'h0A, qsud_pkg::KIND_DATA},     // newline escape
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{qsud_pkg::CH_QUOTE, 1'b1, 1'b1, 8'h22, qsud_pkg::KIND_DATA}, // escaped quote
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{CH_LOWER_Q, 1'b0, 1'b0, 8'h00, qsud_pkg::KIND_DATA},     // unknown escape
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{qsud_pkg::CH_X, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{CH_UPPER_A, 1'b0, 1'b0, 8'h00, qsud_pkg::KIND_DATA},     // upper-case hex digit
        '{qsud_pkg::CH_F, 1'b0, 1'b0, 8'h00, qsud_pkg::KIND_DATA},     // lower-case hex
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{qsud_pkg::CH_X, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{CH_LOWER_G, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_BADHX},    // bad first digit
        '{qsud_pkg::CH_BSL, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{qsud_pkg::CH_X, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{CH_NINE, 1'b0, 1'b0, 8'h00, qsud_pkg::KIND_DATA},
        '{CH_UPPER_G, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_BADHX},    // bad second digit
        '{qsud_pkg::CH_QUOTE, 1'b1, 1'b1, 8'h00, qsud_pkg::KIND_END},  // closes literal
        '{qsud_pkg::CH_TAB, 1'b1, 1'b0, 8'h00, qsud_pkg::KIND_DATA}    // blank in idle
    };

    localparam logic [7:0] ESC_LETTERS [10] = '{
        qsud_pkg::CH_BSL, qsud_pkg::CH_QUOTE, qsud_pkg::CH_ZERO, qsud_pkg::CH_A,
        qsud_pkg::CH_B, qsud_pkg::CH_T, qsud_pkg::CH_N, qsud_pkg::CH_V,
        qsud_pkg::CH_F, qsud_pkg::CH_R
    };

    localparam logic [7:0] BLANKS [6] = '{
        qsud_pkg::CH_SPACE, qsud_pkg::CH_TAB, qsud_pkg::CH_LF,
        qsud_pkg::CH_VT, qsud_pkg::CH_FF, qsud_pkg::CH_CR
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_in   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;

    // Bench copy of the decoder state.
    qsud_pkg::phase_t dec_phase;
    logic [3:0]       dec_high;
    logic [7:0]       esc_rom [256];

    decoded_t   pending_outputs [$];   // results predicted, not yet seen
    int         items_sent = 0;
    int         err_count  = 0;
    bit         quiet      = 1'b0;     // no idling on either side
    bit         hold_req   = 1'b0;     // asks the receiver for a long hold-off

    quoted_string_unescape_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .kind      (kind)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Safety net: the slowest legal run is far shorter than this.
    initial
    begin
        #2_000_000;
        $display("quoted_string_unescape_decoder_tb: errors");
        $finish;
    end

    // Bit 4 set: not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= qsud_pkg::CH_ZERO && c <= CH_NINE)
            return {1'b0, c[3:0]};
        if ((c >= qsud_pkg::CH_A && c <= CH_LOWER_F) ||
            (c >= CH_UPPER_A && c <= CH_UPPER_F))
            return {1'b0, 4'(c[2:0]) + 4'd9};
        return 5'h10;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {qsud_pkg::CH_SPACE, qsud_pkg::CH_TAB, qsud_pkg::CH_LF,
                         qsud_pkg::CH_VT, qsud_pkg::CH_FF, qsud_pkg::CH_CR};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return qsud_pkg::CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_UPPER_A : qsud_pkg::CH_A) + 8'(v) - 8'd10;
    endfunction

    // Steps the bench decoder by one character; gives says whether a result
    // comes out.
    task automatic decode_char(input logic [7:0] c, output bit gives, output decoded_t r);
        logic [4:0] h;
        h     = nibble_of(c);
        gives = 1'b0;
        r     = '{val: 8'h00, kind: qsud_pkg::KIND_DATA};
        case (dec_phase)
            qsud_pkg::PH_BODY:
            begin
                if (c == qsud_pkg::CH_QUOTE)
                begin
                    dec_phase = qsud_pkg::PH_IDLE;
                    gives     = 1'b1;
                    r.kind    = qsud_pkg::KIND_END;
                end
                else if (c == qsud_pkg::CH_BSL)
                    dec_phase = qsud_pkg::PH_ESC;
                else
                begin
                    gives = 1'b1;
                    r.val = c;
                end
            end
            qsud_pkg::PH_ESC:
            begin
                if (c == qsud_pkg::CH_X)
                    dec_phase = qsud_pkg::PH_HEX1;
                else
                begin
                    dec_phase = qsud_pkg::PH_BODY;
                    gives     = 1'b1;
                    r.val     = esc_rom[c];
                end
            end
            qsud_pkg::PH_HEX1:
            begin
                if (h[4])
                begin
                    dec_phase = qsud_pkg::PH_BODY;
                    gives     = 1'b1;
                    r.kind    = qsud_pkg::KIND_BADHX;
                end
                else
                begin
                    dec_high  = h[3:0];
                    dec_phase = qsud_pkg::PH_HEX2;
                end
            end
            qsud_pkg::PH_HEX2:
            begin
                dec_phase = qsud_pkg::PH_BODY;
                gives     = 1'b1;
                if (h[4])
                    r.kind = qsud_pkg::KIND_BADHX;
                else
                    r.val = {dec_high, h[3:0]};
            end
            default:
            begin
                dec_phase = qsud_pkg::PH_IDLE;
                if (c == qsud_pkg::CH_QUOTE)
                    dec_phase = qsud_pkg::PH_BODY;
                else if (!is_blank(c))
                begin
                    gives  = 1'b1;
                    r.kind = qsud_pkg::KIND_NOQ;
                end
            end
        endcase
    endtask

    // Offers one character and returns at the edge where it is taken.
    // Idle gaps come before raising valid, never while it is up.
    task automatic send_char(input logic [7:0] c);
        while (!quiet && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] c);
        bit       gives;
        decoded_t r;
        send_char(c);
        decode_char(c, gives, r);
        if (gives)
            pending_outputs.push_back(r);
    endtask

    // A well-formed literal with random content: blanks, quote, a body of
    // plain bytes, named escapes, odd escapes and hex forms, closing quote.
    // Hex digits go bad now and then. With plain_only the body holds plain bytes alone.
    task automatic send_literal(input int body_len, input bit plain_only);
        int         pick;
        logic [7:0] c;
        repeat ($urandom_range(2))
            send_predicted(BLANKS[$urandom_range(5)]);
        send_predicted(qsud_pkg::CH_QUOTE);
        repeat (body_len)
        begin
            pick = plain_only ? 0 : $urandom_range(99);
            if (pick < 60)
            begin
                do
                    c = 8'($urandom_range(255));
                while (c == qsud_pkg::CH_QUOTE || c == qsud_pkg::CH_BSL);
                send_predicted(c);
            end
            else if (pick < 80)
            begin
                send_predicted(qsud_pkg::CH_BSL);
                if ($urandom_range(1))
                    send_predicted(ESC_LETTERS[$urandom_range(9)]);
                else
                    send_predicted(8'($urandom_range(255)));
            end
            else
            begin
                send_predicted(qsud_pkg::CH_BSL);
                send_predicted(qsud_pkg::CH_X);
                repeat (2)
                begin
                    if ($urandom_range(9) == 0)
                        send_predicted(8'($urandom_range(255)));
                    else
                        send_predicted(hex_char(4'($urandom_range(15))));
                end
            end
        end
        send_predicted(qsud_pkg::CH_QUOTE);
    endtask

    // ------------------------------------------------------------------
    // Request side: reset, hand-written table, then random traffic.
    // ------------------------------------------------------------------
    initial
    begin
        bit       gives;
        decoded_t r;
        bit       did_hold;
        bit       did_drain;

        did_hold  = 1'b0;
        did_drain = 1'b0;
        for (int i = 0; i < 256; i++)
            esc_rom[i] = 8'h00;
        esc_rom[qsud_pkg::CH_BSL]   = 8'h5C;
        esc_rom[qsud_pkg::CH_QUOTE] = 8'h22;
        esc_rom[qsud_pkg::CH_ZERO]  = 8'h00;
        esc_rom[qsud_pkg::CH_A]     = 8'h07;
        esc_rom[qsud_pkg::CH_B]     = 8'h08;
        esc_rom[qsud_pkg::CH_T]     = 8'h09;
        esc_rom[qsud_pkg::CH_N]     = 8'h0A;
        esc_rom[qsud_pkg::CH_V]     = 8'h0B;
        esc_rom[qsud_pkg::CH_F]     = 8'h0C;
        esc_rom[qsud_pkg::CH_R]     = 8'h0D;
        dec_phase = qsud_pkg::PH_IDLE;
        dec_high  = 4'h0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pinned rows still step the bench decoder so its state keeps up.
        foreach (DIRECTED[i])
        begin
            send_char(DIRECTED[i].ch);
            decode_char(DIRECTED[i].ch, gives, r);
            if (DIRECTED[i].pinned)
            begin
                gives = DIRECTED[i].gives;
                r     = '{val: DIRECTED[i].val, kind: DIRECTED[i].kind};
            end
            if (gives)
                pending_outputs.push_back(r);
        end

        while (items_sent < ITEM_COUNT)
        begin
            quiet = (items_sent >= 1000 && items_sent < 1250);
            if (!did_hold && items_sent >= 400)
            begin
                // Output blocked for a long stretch while a long literal keeps
                // coming: the pipe fills and in_stall has to rise.
                did_hold = 1'b1;
                hold_req = 1'b1;
                send_literal(40, 1'b1);
            end
            else if (!did_drain && items_sent >= 800)
            begin
                // Sender goes quiet until every result is out.
                did_drain = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_outputs.size() != 0);
            end
            else if ($urandom_range(99) < 80)
                send_literal($urandom_range(12), 1'b0);
            else
            begin
                // Junk: any byte, in whatever phase the decoder is in.
                repeat ($urandom_range(1, 4))
                    send_predicted(8'($urandom_range(255)));
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_outputs.size() != 0)
            @(posedge clk);
        // Then wait on to catch any stray result.
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("quoted_string_unescape_decoder_tb: clean");
        else
            $display("quoted_string_unescape_decoder_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check each taken result, then pick the next stall.
    // ------------------------------------------------------------------
    initial
    begin
        int       hold_left;
        decoded_t want;

        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("%0t: result with nothing pending: byte %h kind %0d",
                                 $realtime, out_byte, kind);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (out_byte !== want.val || kind !== want.kind)
                    begin
                        err_count++;
                        if (err_count <= REPORT_MAX)
                            $display("%0t: want byte %h kind %0d, got byte %h kind %0d",
                                     $realtime, want.val, want.kind, out_byte, kind);
                    end
                end
            end

            // Hold-off length is counted here, not by the request side.
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

endmodule

FILE: quoted_string_unescape_decoder.f
hdl/qsud_pkg.sv
hdl/quoted_string_unescape_decoder.sv
bench/quoted_string_unescape_decoder_tb.sv
